// ----- design/bcs_pkg.sv -----
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared types, constants and helpers for the bank command scoreboard.
// ----------------------------------------------------------------------------
package bcs_pkg;

  localparam int unsigned ID_W        = 32;
  localparam int unsigned ENG_W       = 3;
  localparam int unsigned RES_W       = 3;
  localparam int unsigned BANK_W      = 2;
  localparam int unsigned NUM_ENGINES = 7;
  localparam int unsigned NUM_CLASSES = 6;
  localparam int unsigned LRU_SPAN    = 4;

  localparam int unsigned INPUT_BANKS    = 2;
  localparam int unsigned OUTPUT_BANKS   = 4;
  localparam int unsigned RESIDUAL_BANKS = 2;
  localparam int unsigned METADATA_BANKS = 2;

  localparam int unsigned ENGINE_WINDOW_DEF = 2;
  localparam int unsigned MAX_USES_DEF      = 7;

  localparam int unsigned TBL_AW    = RES_W + BANK_W;
  localparam int unsigned TBL_DEPTH = 1 << TBL_AW;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [RES_W-1:0] RES_OUTPUT   = 3'd2;
  localparam logic [RES_W-1:0] RES_RESIDUAL = 3'd4;
  localparam logic [RES_W-1:0] RES_METADATA = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_BANK_RD,
    S_BANK_DATA,
    S_NOTE_ZERO,
    S_NOTE_SELF,
    S_NOTE_SCAN,
    S_NOTE_ADD,
    S_BANK_WR,
    S_LRU_RD,
    S_LRU_CMP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   cmd_id;
    logic              dep_valid;
    logic [ID_W-1:0]   dep_id;
    logic [BANK_W-1:0] free_bank;
    logic              was_live;
    logic              last;
  } result_t;

  // bank count of a resource class
  function automatic logic [4:0] class_banks(input logic [RES_W-1:0] r);
    logic [4:0] n;
    unique case (r)
      RES_OUTPUT:   n = 5'(OUTPUT_BANKS);
      RES_RESIDUAL: n = 5'(RESIDUAL_BANKS);
      RES_METADATA: n = 5'(METADATA_BANKS);
      default:      n = 5'(INPUT_BANKS);
    endcase
    return n;
  endfunction

  // banks of a class that can hold a recorded user (bank index is 2 bits)
  function automatic logic [2:0] lru_limit(input logic [RES_W-1:0] r);
    logic [4:0] n;
    n = class_banks(r);
    return (n > 5'(LRU_SPAN)) ? 3'(LRU_SPAN) : n[2:0];
  endfunction

  // class has never-written banks beyond the addressable ones
  function automatic logic lru_tail(input logic [RES_W-1:0] r);
    return class_banks(r) > 5'(LRU_SPAN);
  endfunction

endpackage

// ----- design/bcs_ram.sv -----
// ----------------------------------------------------------------------------
// bcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bcs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/bcs_cmp.sv -----
// ----------------------------------------------------------------------------
// bcs_cmp
// Shared unsigned compare unit: equality and less-than.
// ----------------------------------------------------------------------------
module bcs_cmp #(
  parameter int unsigned WIDTH = 32
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic             eq,
  output logic             lt
);

  assign eq = (a == b);
  assign lt = (a < b);

endmodule

// ----- design/bank_command_scoreboard.sv -----
// ----------------------------------------------------------------------------
// bank_command_scoreboard
// Hazard scoreboard for engine commands built from bank-use transactions.
//
//   channel  dir  signals                    content
//   s_axis   in   tvalid tready tdata tlast  one bank use; tlast = last_use
//   m_axis   out  tvalid tready tdata tuser  one result; tuser = dep_valid,
//                 tlast                      tlast = last_result
//
// In one transaction each dependency candidate is checked by the single compare
// unit, one seen-list entry per cycle, and the least recently used search reads
// the bank table RAM one bank per read/compare state pair (S_LRU_RD, S_LRU_CMP).
// rst is synchronous; the bank table is backed by valid bits, so no clear pass.
// Results sit in a two-entry output register; the next input is taken while
// they drain, and the sequencer holds before writing results until it empties.
// ----------------------------------------------------------------------------
module bank_command_scoreboard
  import bcs_pkg::*;
#(
  parameter int unsigned ENGINE_WINDOW = ENGINE_WINDOW_DEF,
  parameter int unsigned MAX_USES      = MAX_USES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // engine[2:0] is_store[3] consumes_source[4] resource[7:5] bank_index[9:8]
  // is_write[10] query_resource[13:11]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // command_id[31:0] dep_id[63:32] free_bank[65:64] bank_was_live[66]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // dep_valid[0]
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  localparam int unsigned SEEN_DEPTH = MAX_USES + 1;
  localparam int unsigned SEEN_AW    = $clog2(SEEN_DEPTH);
  localparam int unsigned SEEN_CW    = $clog2(SEEN_DEPTH + 1);
  localparam int unsigned ECNT_W     = $clog2(ENGINE_WINDOW + 1);

  state_t state, state_next;

  logic [ENG_W-1:0]  i_eng;
  logic              i_store;
  logic              i_cons;
  logic [RES_W-1:0]  i_res;
  logic [BANK_W-1:0] i_bank;
  logic              i_wr;
  logic              i_last;
  logic [RES_W-1:0]  i_query;

  logic [ID_W-1:0] next_id;
  logic [ID_W-1:0] cur_id;
  logic            in_cmd;

  logic [ENGINE_WINDOW-1:0][ID_W-1:0] eng_ids [NUM_ENGINES];
  logic [ECNT_W-1:0]                  eng_cnt [NUM_ENGINES];
  logic [ENGINE_WINDOW-1:0][ID_W-1:0] eng_row;
  logic [ENGINE_WINDOW-1:0][ID_W-1:0] eng_row_next;

  logic [LRU_SPAN-1:0]  live;
  logic [TBL_DEPTH-1:0] tbl_valid;
  logic [TBL_AW-1:0]    rd_addr;
  logic [TBL_AW-1:0]    ram_raddr;
  logic                 ram_we;
  logic [ID_W-1:0]      ram_rdata;
  logic [ID_W-1:0]      tbl_eff;

  logic [ID_W-1:0]    seen [SEEN_DEPTH];
  logic [SEEN_CW-1:0] seen_cnt;
  logic [SEEN_CW-1:0] scan_idx;

  logic [ID_W-1:0] dep_cand;
  logic            note_bank;
  logic [ID_W-1:0] pend_dep [2];
  logic [1:0]      pend_n;

  logic              was_live;
  logic [2:0]        lru_idx;
  logic [ID_W-1:0]   lru_low;
  logic [BANK_W-1:0] lru_best;
  logic [BANK_W-1:0] free_bank;

  result_t    out_slot [2];
  logic [1:0] out_n;
  result_t    res0, res1;

  logic [ID_W-1:0] cmp_a, cmp_b;
  logic            cmp_eq, cmp_lt;

  logic   accept, bank_ok, eng_ok, eng_full, q_ok, lru_done, scan_end;
  state_t note_ret;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign bank_ok  = (i_res < RES_W'(NUM_CLASSES)) && ({3'b000, i_bank} < class_banks(i_res));
  assign eng_ok   = i_eng < ENG_W'(NUM_ENGINES);
  assign eng_full = eng_ok && (eng_cnt[i_eng] >= ECNT_W'(ENGINE_WINDOW));
  assign q_ok     = i_query < RES_W'(NUM_CLASSES);
  assign lru_done = lru_idx >= lru_limit(i_query);
  assign scan_end = scan_idx >= seen_cnt;
  assign tbl_eff  = tbl_valid[rd_addr] ? ram_rdata : '0;
  assign note_ret = note_bank ? S_BANK_WR : S_BANK_RD;

  always_comb begin
    eng_row = eng_ok ? eng_ids[i_eng] : '0;
    if (eng_full) begin
      eng_row_next = eng_row >> ID_W;
      eng_row_next[ENGINE_WINDOW-1] = next_id;
    end else begin
      eng_row_next = eng_row;
      for (int i = 0; i < ENGINE_WINDOW; i++) begin
        if (ECNT_W'(i) == eng_cnt[i_eng]) begin
          eng_row_next[i] = next_id;
        end
      end
    end
  end

  bcs_cmp #(.WIDTH(ID_W)) u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .eq (cmp_eq),
    .lt (cmp_lt)
  );

  bcs_ram #(.WIDTH(ID_W), .DEPTH(TBL_DEPTH)) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({i_res, i_bank}),
    .wdata (cur_id),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (accept) state_next = S_START;
      S_START:     state_next = (!in_cmd && eng_full) ? S_NOTE_ZERO : S_BANK_RD;
      S_BANK_RD:   state_next = bank_ok ? S_BANK_DATA : S_LRU_RD;
      S_BANK_DATA: state_next = S_NOTE_ZERO;
      S_NOTE_ZERO: state_next = cmp_eq ? note_ret : S_NOTE_SELF;
      S_NOTE_SELF: state_next = cmp_eq ? note_ret : S_NOTE_SCAN;
      S_NOTE_SCAN: begin
        priority if (scan_end) state_next = S_NOTE_ADD;
        else if (cmp_eq)       state_next = note_ret;
        else                   state_next = S_NOTE_SCAN;
      end
      S_NOTE_ADD:  state_next = note_ret;
      S_BANK_WR:   state_next = S_LRU_RD;
      S_LRU_RD:    state_next = (!q_ok || lru_done) ? S_OUT : S_LRU_CMP;
      S_LRU_CMP:   state_next = S_LRU_RD;
      S_OUT:       if (out_n == 2'd0) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = {i_res, i_bank};
    cmp_a         = '0;
    cmp_b         = '0;
    unique case (state)
      S_IDLE:      s_axis_tready = 1'b1;
      S_NOTE_ZERO: cmp_a = dep_cand;
      S_NOTE_SELF: begin
        cmp_a = dep_cand;
        cmp_b = cur_id;
      end
      S_NOTE_SCAN: begin
        cmp_a = seen[scan_idx[SEEN_AW-1:0]];
        cmp_b = dep_cand;
      end
      S_BANK_WR:   ram_we = 1'b1;
      S_LRU_RD:    ram_raddr = {i_query, lru_idx[BANK_W-1:0]};
      S_LRU_CMP: begin
        cmp_a = tbl_eff;
        cmp_b = lru_low;
      end
      default: ;
    endcase
  end

  always_comb begin
    res0.cmd_id    = cur_id;
    res0.dep_valid = pend_n != 2'd0;
    res0.dep_id    = (pend_n != 2'd0) ? pend_dep[0] : '0;
    res0.free_bank = free_bank;
    res0.was_live  = was_live;
    res0.last      = pend_n != 2'd2;
    res1           = res0;
    res1.dep_valid = 1'b1;
    res1.dep_id    = pend_dep[1];
    res1.last      = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      next_id   <= ID_W'(1);
      cur_id    <= '0;
      in_cmd    <= 1'b0;
      live      <= '0;
      tbl_valid <= '0;
      seen_cnt  <= '0;
      pend_n    <= '0;
      out_n     <= '0;
      for (int e = 0; e < NUM_ENGINES; e++) begin
        eng_cnt[e] <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            i_eng   <= s_axis_tdata[2:0];
            i_store <= s_axis_tdata[3];
            i_cons  <= s_axis_tdata[4];
            i_res   <= s_axis_tdata[7:5];
            i_bank  <= s_axis_tdata[9:8];
            i_wr    <= s_axis_tdata[10];
            i_query <= s_axis_tdata[13:11];
            i_last  <= s_axis_tlast;
          end
        end
        S_START: begin
          pend_n    <= '0;
          was_live  <= 1'b0;
          lru_idx   <= '0;
          free_bank <= '0;
          scan_idx  <= '0;
          note_bank <= 1'b0;
          if (!in_cmd) begin
            cur_id   <= next_id;
            next_id  <= (next_id == '1) ? ID_W'(1) : next_id + ID_W'(1);
            in_cmd   <= 1'b1;
            seen_cnt <= '0;
            if (eng_ok) begin
              eng_ids[i_eng] <= eng_row_next;
              if (eng_full) begin
                dep_cand <= eng_row[0];
              end else begin
                eng_cnt[i_eng] <= eng_cnt[i_eng] + ECNT_W'(1);
              end
            end
          end
        end
        S_BANK_RD: rd_addr <= {i_res, i_bank};
        S_BANK_DATA: begin
          dep_cand  <= tbl_eff;
          note_bank <= 1'b1;
          scan_idx  <= '0;
          if (i_res == RES_OUTPUT) begin
            was_live <= live[i_bank];
          end
        end
        S_NOTE_SCAN: begin
          if (!scan_end && !cmp_eq) begin
            scan_idx <= scan_idx + SEEN_CW'(1);
          end
        end
        S_NOTE_ADD: begin
          if (seen_cnt < SEEN_CW'(SEEN_DEPTH)) begin
            seen[seen_cnt[SEEN_AW-1:0]] <= dep_cand;
            seen_cnt <= seen_cnt + SEEN_CW'(1);
          end
          pend_dep[pend_n[0]] <= dep_cand;
          pend_n <= pend_n + 2'd1;
        end
        S_BANK_WR: begin
          tbl_valid[{i_res, i_bank}] <= 1'b1;
          lru_idx <= '0;
          if (i_res == RES_OUTPUT) begin
            if (i_wr) begin
              live[i_bank] <= 1'b1;
            end else if (i_store || i_cons) begin
              live[i_bank] <= 1'b0;
            end
          end
        end
        S_LRU_RD: begin
          rd_addr <= {i_query, lru_idx[BANK_W-1:0]};
          if (!q_ok) begin
            free_bank <= '0;
          end else if (lru_done) begin
            // banks past the addressable ones still read as zero
            free_bank <= (lru_tail(i_query) && (lru_low != '0)) ? '0 : lru_best;
          end
        end
        S_LRU_CMP: begin
          if (lru_idx == 3'd0 || cmp_lt) begin
            lru_low  <= tbl_eff;
            lru_best <= lru_idx[BANK_W-1:0];
          end
          lru_idx <= lru_idx + 3'd1;
        end
        S_OUT: begin
          if (out_n == 2'd0 && i_last) begin
            in_cmd <= 1'b0;
          end
        end
        default: ;
      endcase

      if (m_axis_tvalid && m_axis_tready) begin
        if (out_n == 2'd2) begin
          out_slot[0] <= out_slot[1];
          out_n       <= 2'd1;
        end else begin
          out_n <= 2'd0;
        end
      end else if (state == S_OUT && out_n == 2'd0) begin
        out_slot[0] <= res0;
        out_slot[1] <= res1;
        out_n       <= (pend_n == 2'd2) ? 2'd2 : 2'd1;
      end
    end
  end

  assign m_axis_tvalid = out_n != 2'd0;
  assign m_axis_tdata  = {5'b00000, out_slot[0].was_live, out_slot[0].free_bank,
                          out_slot[0].dep_id, out_slot[0].cmd_id};
  assign m_axis_tuser  = out_slot[0].dep_valid;
  assign m_axis_tlast  = out_slot[0].last;

`ifndef NO_ASSERTIONS
  a_pair_back_to_back: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tuser)
    else $error("second result of a transaction not presented");

  a_nodep_alone: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("result without dependency is not the last one");

  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    (next_id != '0) && (!m_axis_tvalid || (out_slot[0].cmd_id != '0)))
    else $error("command id reached zero");

  a_counts: assert property (@(posedge clk) disable iff (rst)
    (pend_n <= 2'd2) && (seen_cnt <= SEEN_CW'(SEEN_DEPTH)))
    else $error("dependency counters out of range");
`endif

endmodule
